// File: src/bpa_pkg.sv
// Shared types and constants of the bitmap page allocator.
// Used by the store, scan, register and top-level modules; depends on nothing.
package bpa_pkg;

  localparam int PAGES     = 4096;
  localparam int PAGE_W    = $clog2(PAGES);      // page index width
  localparam int NUM_W     = PAGE_W + 1;         // page counts up to PAGES
  localparam int WORD_BITS = 8;                  // bitmap word scanned per cycle
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WORD_W    = PAGE_W - BIT_W;     // bitmap word address width
  localparam int FRAME_W   = 36;
  localparam int LIMIT_W   = 37;
  localparam int REF_W     = 16;
  localparam logic [REF_W-1:0] REF_MAX = 16'hFFFF;

  localparam int APB_AW = 5;
  localparam int APB_DW = 64;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_PAGES = 2'd1,
    REG_LIMIT = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_RETAIN  = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_ROOM   = 3'd1,
    ST_BAD_FRAME = 3'd2,
    ST_PAGE_FREE = 3'd3,
    ST_AT_LIMIT  = 3'd4
  } status_t;

  // Request from the sequencer to the page store.
  typedef struct packed {
    logic [PAGE_W-1:0] page;     // page for count read and for writes
    logic              cnt_rd;   // read the reference count of page
    logic              wr;       // write count and used bit of page
    logic [REF_W-1:0]  wcount;
    logic              wbit;
    logic              map_rd;   // read one bitmap word
    logic [WORD_W-1:0] map_word;
  } store_req_t;

endpackage

// File: src/bpa_store.sv
// Page store: reference-count memory and used-bitmap memory.
// Depends on bpa_pkg for widths and the request struct.
module bpa_store (
  input  logic                          clk,
  input  bpa_pkg::store_req_t           req,
  output logic [bpa_pkg::REF_W-1:0]     rd_count,
  output logic [bpa_pkg::WORD_BITS-1:0] rd_word
);

  logic [bpa_pkg::REF_W-1:0]     cnt_mem [bpa_pkg::PAGES];
  logic [bpa_pkg::WORD_BITS-1:0] map_mem [bpa_pkg::PAGES / bpa_pkg::WORD_BITS];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      cnt_mem[req.page] <= req.wcount;
    end
    if (req.cnt_rd) begin
      rd_count <= cnt_mem[req.page];
    end
  end

  // The bitmap is written one bit at a time and read a whole word at a time.
  always_ff @(posedge clk) begin
    if (req.wr) begin
      map_mem[req.page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W]][req.page[bpa_pkg::BIT_W-1:0]]
        <= req.wbit;
    end
    if (req.map_rd) begin
      rd_word <= map_mem[req.map_word];
    end
  end

endmodule

// File: src/bpa_scan.sv
// First-fit run scanner: walks one bitmap word per step, carrying the open run.
// Depends on bpa_pkg for widths.
module bpa_scan (
  input  logic                          clk,
  input  logic                          init,
  input  logic                          step,
  input  logic [bpa_pkg::WORD_BITS-1:0] word,      // 1 marks a used page
  input  logic [bpa_pkg::WORD_W-1:0]    word_idx,
  input  logic [bpa_pkg::NUM_W-1:0]     pc,
  input  logic [bpa_pkg::NUM_W-1:0]     count,
  output logic                          hit,
  output logic [bpa_pkg::PAGE_W-1:0]    hit_start
);

  logic [bpa_pkg::NUM_W-1:0]  run;
  logic [bpa_pkg::PAGE_W-1:0] start;
  logic [bpa_pkg::NUM_W-1:0]  run_next;
  logic [bpa_pkg::PAGE_W-1:0] start_next;
  logic                       hit_c;

  always_comb begin
    logic [bpa_pkg::NUM_W-1:0] pidx;
    run_next   = run;
    start_next = start;
    hit_c      = 1'b0;
    for (int j = 0; j < bpa_pkg::WORD_BITS; j++) begin
      pidx = {1'b0, word_idx, bpa_pkg::BIT_W'(j)};
      if (!hit_c && (pidx < pc)) begin
        if (!word[j]) begin
          if (run_next == '0) begin
            start_next = pidx[bpa_pkg::PAGE_W-1:0];
          end
          run_next = run_next + 1'b1;
          if (run_next >= count) begin
            hit_c = 1'b1;
          end
        end else begin
          run_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      run   <= '0;
      start <= '0;
    end else if (step) begin
      run   <= run_next;
      start <= start_next;
    end
  end

  assign hit       = hit_c;
  assign hit_start = start_next;

endmodule

// File: src/bpa_regs.sv
// Configuration registers behind the APB-style port.
// Depends on bpa_pkg for widths and register indexes.
module bpa_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpa_pkg::APB_AW-1:0]    paddr,
  input  logic [bpa_pkg::APB_DW-1:0]    pwdata,
  output logic [bpa_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output logic [bpa_pkg::FRAME_W-1:0]   base_frame,
  output logic [bpa_pkg::LIMIT_W-1:0]   direct_limit,
  output logic [bpa_pkg::NUM_W-1:0]     seg_pages
);

  logic [bpa_pkg::NUM_W-1:0] page_count;
  bpa_pkg::reg_idx_t         sel;
  logic                      wr_en;

  assign pready = 1'b1;
  assign sel    = bpa_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame   <= '0;
      page_count   <= bpa_pkg::NUM_W'(bpa_pkg::PAGES);
      direct_limit <= {1'b1, {bpa_pkg::FRAME_W{1'b0}}};
    end else if (wr_en) begin
      unique case (sel)
        bpa_pkg::REG_BASE:  base_frame   <= pwdata[bpa_pkg::FRAME_W-1:0];
        bpa_pkg::REG_PAGES: page_count   <= pwdata[bpa_pkg::NUM_W-1:0];
        bpa_pkg::REG_LIMIT: direct_limit <= pwdata[bpa_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      bpa_pkg::REG_BASE:  prdata = bpa_pkg::APB_DW'(base_frame);
      bpa_pkg::REG_PAGES: prdata = bpa_pkg::APB_DW'(page_count);
      bpa_pkg::REG_LIMIT: prdata = bpa_pkg::APB_DW'(direct_limit);
      default:            prdata = '0;
    endcase
  end

  // Values above the store size act as the store size.
  assign seg_pages = (page_count > bpa_pkg::NUM_W'(bpa_pkg::PAGES))
                   ? bpa_pkg::NUM_W'(bpa_pkg::PAGES) : page_count;

endmodule

// File: src/bitmap_page_allocator_refcount.sv
// Top level of the first-fit bitmap page allocator with reference counts.
// Depends on bpa_pkg, bpa_regs, bpa_store and bpa_scan.
//
// This block manages the 4096 page frames of one segment with a used bitmap and a
// 16-bit reference count per page, and answers allocate, free-range, retain and
// release requests with exactly one result transfer each. It works on one request
// at a time and drops s_tready until that request's result is in the output
// register; a finished result may wait there while the next request is taken.
// After reset a clearing pass writes every page of the store, one page a cycle,
// and the block accepts no request until that pass is done; the configuration
// port is live throughout. An allocate first runs its checks in S_ACHK and
// S_ACHK2, then scans one 8-page bitmap word per cycle up to the word where the
// first long-enough run completes (at most ceil(seg_pages/8) words, 512 for a
// full segment), then marks one allocated page per cycle. The word scan is set by
// the single bitmap read port and the single run scanner. A free range reads and
// writes each of its pages in turn, a retain or release reads its one page and
// writes it if in use, and a rejected request ends at the check or scan that fails.
module bitmap_page_allocator_refcount (
  input  logic                        clk,
  input  logic                        rst,
  // Request stream.
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [55:0]                 s_tdata,  // frame[35:0], count[48:36], zero
  input  logic [1:0]                  s_tuser,  // action[1:0]
  // Result stream.
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,  // alloc_frame[35:0], skipped_pages[48:36],
                                                // free_pages[61:49], zero
  output logic [2:0]                  m_tuser,  // status[2:0]
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpa_pkg::APB_AW-1:0]  paddr,
  input  logic [bpa_pkg::APB_DW-1:0]  pwdata,
  output logic [bpa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_LOC   = 11'b00000000100,
    S_LOC2  = 11'b00000001000,
    S_ACHK  = 11'b00000010000,
    S_ACHK2 = 11'b00000100000,
    S_SRCH  = 11'b00001000000,
    S_FIT   = 11'b00010000000,
    S_MARK  = 11'b00100000000,
    S_RD    = 11'b01000000000,
    S_WR    = 11'b10000000000
  } state_t;

  localparam int NW = bpa_pkg::NUM_W;
  localparam int FW = bpa_pkg::FRAME_W;
  localparam int PW = bpa_pkg::PAGE_W;

  state_t state;
  logic   done;      // result ready to move into the output register

  bpa_pkg::action_t           act;
  bpa_pkg::status_t           status;
  logic [FW-1:0]              frame_r;
  logic [NW-1:0]              count_r;
  logic [FW-1:0]              off_r;
  logic [bpa_pkg::LIMIT_W-1:0] room_r;
  logic [NW-1:0]              limit_r;
  logic [PW-1:0]              idx;
  logic [NW-1:0]              rem;
  logic [bpa_pkg::WORD_W-1:0] waddr;
  logic [bpa_pkg::WORD_W-1:0] pword;
  logic [PW-1:0]              start_r;
  logic [NW-1:0]              skipped;
  logic [FW-1:0]              alloc_r;
  logic [NW-1:0]              free_total;

  logic [FW-1:0]              out_alloc;
  bpa_pkg::status_t           out_status;
  logic [NW-1:0]              out_skip;
  logic [NW-1:0]              out_free;

  logic [FW-1:0]               base_frame;
  logic [bpa_pkg::LIMIT_W-1:0] direct_limit;
  logic [NW-1:0]               seg_pages;

  bpa_pkg::store_req_t            req;
  logic [bpa_pkg::REF_W-1:0]      rd_count;
  logic [bpa_pkg::WORD_BITS-1:0]  rd_word;
  logic                           hit;
  logic [PW-1:0]                  hit_start;

  logic [FW:0]                 loc_diff;
  logic [bpa_pkg::LIMIT_W:0]   room_diff;
  logic                        last_word;

  bpa_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .base_frame   (base_frame),
    .direct_limit (direct_limit),
    .seg_pages    (seg_pages)
  );

  bpa_store u_store (
    .clk      (clk),
    .req      (req),
    .rd_count (rd_count),
    .rd_word  (rd_word)
  );

  bpa_scan u_scan (
    .clk       (clk),
    .init      (state == S_ACHK2),
    .step      (state == S_SRCH),
    .word      (rd_word),
    .word_idx  (pword),
    .pc        (seg_pages),
    .count     (count_r),
    .hit       (hit),
    .hit_start (hit_start)
  );

  assign s_tready  = (state == S_IDLE) && !done;
  assign loc_diff  = {1'b0, frame_r} - {1'b0, base_frame};
  assign room_diff = {1'b0, direct_limit} - {2'b00, base_frame};
  assign last_word = ({1'b0, pword, {bpa_pkg::BIT_W{1'b0}}} + NW'(bpa_pkg::WORD_BITS))
                     >= seg_pages;

  // Store requests follow the sequencer state.
  always_comb begin
    req          = '0;
    req.page     = idx;
    req.map_word = waddr;
    unique case (state)
      S_CLEAR: begin
        req.wr = 1'b1;
      end
      S_RD: begin
        req.cnt_rd = 1'b1;
      end
      S_MARK: begin
        req.wr     = 1'b1;
        req.wcount = bpa_pkg::REF_W'(1);
        req.wbit   = 1'b1;
      end
      S_ACHK2: begin
        req.map_rd   = 1'b1;
        req.map_word = '0;
      end
      S_SRCH: begin
        req.map_rd = 1'b1;
      end
      S_WR: begin
        // A page is in use exactly when its count is nonzero.
        if (rd_count != '0) begin
          unique case (act)
            bpa_pkg::ACT_RETAIN: begin
              req.wr     = (rd_count != bpa_pkg::REF_MAX);
              req.wcount = rd_count + 1'b1;
              req.wbit   = 1'b1;
            end
            default: begin
              req.wr     = 1'b1;
              req.wcount = rd_count - 1'b1;
              req.wbit   = (rd_count != bpa_pkg::REF_W'(1));
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      done       <= 1'b0;
      idx        <= '0;
      free_total <= NW'(bpa_pkg::PAGES);
    end else begin
      unique case (state)
        S_CLEAR: begin
          idx <= idx + 1'b1;
          if (idx == PW'(bpa_pkg::PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            act     <= bpa_pkg::action_t'(s_tuser);
            frame_r <= s_tdata[FW-1:0];
            count_r <= s_tdata[FW+NW-1:FW];
            status  <= bpa_pkg::ST_OK;
            skipped <= '0;
            alloc_r <= '0;
            state   <= (bpa_pkg::action_t'(s_tuser) == bpa_pkg::ACT_ALLOC) ? S_ACHK : S_LOC;
          end
        end
        S_LOC: begin
          off_r <= loc_diff[FW-1:0];
          if (frame_r == '0) begin
            status <= bpa_pkg::ST_BAD_FRAME;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (act == bpa_pkg::ACT_FREE && count_r == '0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (loc_diff[FW]) begin
            status <= bpa_pkg::ST_BAD_FRAME;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_LOC2;
          end
        end
        S_LOC2: begin
          idx <= off_r[PW-1:0];
          rem <= (act == bpa_pkg::ACT_FREE) ? count_r : NW'(1);
          if ((off_r >= FW'(seg_pages)) ||
              (act == bpa_pkg::ACT_FREE &&
               ({1'b0, off_r[NW-1:0]} + {1'b0, count_r}) > {1'b0, seg_pages})) begin
            status <= bpa_pkg::ST_BAD_FRAME;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          unique case (act)
            bpa_pkg::ACT_RETAIN: begin
              if (rd_count == '0) begin
                status <= bpa_pkg::ST_PAGE_FREE;
              end else if (rd_count == bpa_pkg::REF_MAX) begin
                status <= bpa_pkg::ST_AT_LIMIT;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            bpa_pkg::ACT_RELEASE: begin
              if (rd_count == '0) begin
                status <= bpa_pkg::ST_PAGE_FREE;
              end else if (rd_count == bpa_pkg::REF_W'(1)) begin
                free_total <= free_total + 1'b1;
              end
              done  <= 1'b1;
              state <= S_IDLE;
            end
            default: begin
              if (rd_count == '0) begin
                skipped <= skipped + 1'b1;
              end else if (rd_count == bpa_pkg::REF_W'(1)) begin
                free_total <= free_total + 1'b1;
              end
              if (rem == NW'(1)) begin
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                rem   <= rem - 1'b1;
                idx   <= idx + 1'b1;
                state <= S_RD;
              end
            end
          endcase
        end
        S_ACHK: begin
          room_r <= room_diff[bpa_pkg::LIMIT_W-1:0];
          if (count_r == '0 || free_total < count_r || room_diff[bpa_pkg::LIMIT_W] ||
              room_diff == '0) begin
            status <= bpa_pkg::ST_NO_ROOM;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_ACHK2;
          end
        end
        S_ACHK2: begin
          limit_r <= (room_r < bpa_pkg::LIMIT_W'(seg_pages)) ? room_r[NW-1:0] : seg_pages;
          pword   <= '0;
          waddr   <= bpa_pkg::WORD_W'(1);
          if (((room_r < bpa_pkg::LIMIT_W'(seg_pages)) ? room_r[NW-1:0] : seg_pages)
              < count_r) begin
            status <= bpa_pkg::ST_NO_ROOM;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (hit) begin
            start_r <= hit_start;
            state   <= S_FIT;
          end else if (last_word) begin
            status <= bpa_pkg::ST_NO_ROOM;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            pword <= waddr;
            waddr <= waddr + 1'b1;
          end
        end
        S_FIT: begin
          idx <= start_r;
          rem <= count_r;
          // Only the first run found is tried.
          if (({2'b00, start_r} + {1'b0, count_r}) > {1'b0, limit_r}) begin
            status <= bpa_pkg::ST_NO_ROOM;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_MARK;
          end
        end
        S_MARK: begin
          idx <= idx + 1'b1;
          rem <= rem - 1'b1;
          if (rem == NW'(1)) begin
            free_total <= free_total - count_r;
            alloc_r    <= base_frame + FW'(start_r);
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Output register: a finished result moves in once the slot is free.
      if (done && (!m_tvalid || m_tready)) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done && (!m_tvalid || m_tready)) begin
      m_tvalid   <= 1'b1;
      out_alloc  <= alloc_r;
      out_status <= status;
      out_skip   <= skipped;
      out_free   <= free_total;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {2'b00, out_free, out_skip, out_alloc};
  assign m_tuser = out_status;

  // Checks.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_total <= NW'(bpa_pkg::PAGES))
    else $error("free page total exceeds the store size");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in progress");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !req.wr)
    else $error("store written while idle");

  a_mark_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK) |-> (rem != '0))
    else $error("marking ran past the run length");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (done && (!m_tvalid || m_tready)) |=> (m_tvalid && !done))
    else $error("finished result not moved to the output register");

endmodule
